>>> rtl/tctd_pkg.sv
package tctd_pkg;

  // default channel count and per-tick result limit
  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned MAX_RESULTS      = 4;
  localparam int unsigned NRES_W           = 3;

  // field widths
  localparam int unsigned REG_W     = 16;
  localparam int unsigned ELAPSED_W = 20;
  localparam int unsigned TIME_W    = 26;
  localparam int unsigned CHAN_W    = 6;
  localparam int unsigned VOL_W     = 8;
  localparam int unsigned DIVR_W    = 8;
  localparam int unsigned DIV_CNT_W = 5;

  // command selector codes
  localparam logic [REG_W-1:0] OP_WHOLE_NOTE = 16'd0;
  localparam logic [REG_W-1:0] OP_PLAY       = 16'd1;
  localparam logic [REG_W-1:0] OP_PAUSE      = 16'd2;
  localparam logic [REG_W-1:0] OP_IRQ        = 16'd3;
  localparam logic [REG_W-1:0] TONE_BASE     = 16'd4;

  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [9:0]        US_PER_MS = 10'd1000;

  typedef enum logic [1:0] {
    KIND_TONE   = 2'd0,
    KIND_EXPIRE = 2'd1,
    KIND_PLAY   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_TONE,
    S_READ,
    S_UPDATE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic                 action;
    logic [REG_W-1:0]     reg_a;
    logic [REG_W-1:0]     reg_b;
    logic [REG_W-1:0]     reg_c;
    logic [ELAPSED_W-1:0] elapsed_us;
  } item_t;

  typedef struct packed {
    kind_e             kind;
    logic [CHAN_W-1:0] channel;
    logic [REG_W-1:0]  freq_centihz;
    logic [VOL_W-1:0]  volume;
    logic [TIME_W-1:0] note_time_us;
    logic              irq_valid;
    logic [REG_W-1:0]  irq_message;
    logic              playing;
    logic              last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec_cmd;
    logic div_start;
    logic tone_apply;
    logic ram_read;
    logic chan_apply;
    logic finish_push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick;
    logic tone;
    logic div_zero;
    logic div_busy;
    logic out_free;
    logic pend_valid;
    logic last_ch;
    logic emit;
  } status_t;

endpackage

>>> rtl/tctd_in_if.sv
interface tctd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [tctd_pkg::REG_W-1:0]     reg_a;
  logic [tctd_pkg::REG_W-1:0]     reg_b;
  logic [tctd_pkg::REG_W-1:0]     reg_c;
  logic [tctd_pkg::ELAPSED_W-1:0] elapsed_us;

  modport source (
    output valid, action, reg_a, reg_b, reg_c, elapsed_us,
    input  ready
  );

  modport sink (
    input  valid, action, reg_a, reg_b, reg_c, elapsed_us,
    output ready
  );
endinterface

>>> rtl/tctd_out_if.sv
interface tctd_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [tctd_pkg::CHAN_W-1:0] channel;
  logic [tctd_pkg::REG_W-1:0]  freq_centihz;
  logic [tctd_pkg::VOL_W-1:0]  volume;
  logic [tctd_pkg::TIME_W-1:0] note_time_us;
  logic                        irq_valid;
  logic [tctd_pkg::REG_W-1:0]  irq_message;
  logic                        playing;
  logic                        last;

  modport source (
    output valid, kind, channel, freq_centihz, volume, note_time_us,
    output irq_valid, irq_message, playing, last,
    input  ready
  );

  modport sink (
    input  valid, kind, channel, freq_centihz, volume, note_time_us,
    input  irq_valid, irq_message, playing, last,
    output ready
  );
endinterface

>>> rtl/tctd_ram.sv
module tctd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tctd_div.sv
module tctd_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tctd_pkg::TIME_W-1:0]       dividend_i,
  input  logic [tctd_pkg::DIVR_W-1:0]       divisor_i,
  output logic                              busy_o,
  output logic [tctd_pkg::TIME_W-1:0]       quotient_o
);

  localparam int unsigned TW = tctd_pkg::TIME_W;
  localparam int unsigned DW = tctd_pkg::DIVR_W;
  localparam int unsigned CW = tctd_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [TW-1:0] quo_q, quo_d;
  logic [DW:0]   trial;
  logic          fits;

  // one restoring step per cycle, dividend shifts out as quotient shifts in
  assign trial = {rem_q, quo_q[TW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
      quo_d = {quo_q[TW-2:0], fits};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(TW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/tctd_ctrl.sv
module tctd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tctd_pkg::status_t status_i,
  output tctd_pkg::cmd_t    cmd_o
);

  tctd_pkg::state_e state_q, state_d;
  logic             stall;

  // a result waits on the pending slot while the output register is full
  assign stall = status_i.emit && status_i.pend_valid && !status_i.out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tctd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = tctd_pkg::S_DECODE;
        end
      end
      tctd_pkg::S_DECODE: begin
        priority if (status_i.tick) begin
          state_d = tctd_pkg::S_READ;
        end else if (status_i.tone) begin
          state_d = status_i.div_zero ? tctd_pkg::S_TONE : tctd_pkg::S_DIV;
        end else begin
          state_d = tctd_pkg::S_FINISH;
        end
      end
      tctd_pkg::S_DIV: begin
        if (!status_i.div_busy) begin
          state_d = tctd_pkg::S_TONE;
        end
      end
      tctd_pkg::S_TONE: begin
        state_d = tctd_pkg::S_FINISH;
      end
      tctd_pkg::S_READ: begin
        state_d = tctd_pkg::S_UPDATE;
      end
      tctd_pkg::S_UPDATE: begin
        if (!stall) begin
          state_d = status_i.last_ch ? tctd_pkg::S_FINISH : tctd_pkg::S_READ;
        end
      end
      tctd_pkg::S_FINISH: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          state_d = tctd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tctd_pkg::S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tctd_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      tctd_pkg::S_DECODE: begin
        cmd_o.exec_cmd  = 1'b1;
        cmd_o.div_start = status_i.tone && !status_i.div_zero;
      end
      tctd_pkg::S_DIV: begin
      end
      tctd_pkg::S_TONE: begin
        cmd_o.tone_apply = 1'b1;
      end
      tctd_pkg::S_READ: begin
        cmd_o.ram_read = 1'b1;
      end
      tctd_pkg::S_UPDATE: begin
        cmd_o.chan_apply = !stall;
      end
      tctd_pkg::S_FINISH: begin
        cmd_o.finish_push = status_i.pend_valid && status_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tctd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/tctd_dpath.sv
module tctd_dpath #(
  parameter int unsigned NUM_CHANNELS = tctd_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tctd_pkg::item_t   item_i,
  input  tctd_pkg::cmd_t    cmd_i,
  output tctd_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tctd_pkg::result_t out_res_o
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned TW   = tctd_pkg::TIME_W;
  localparam int unsigned RW   = tctd_pkg::REG_W;
  localparam int unsigned NW   = tctd_pkg::NRES_W;

  // latched item
  tctd_pkg::item_t item_q, item_d;

  // device state
  logic [TW-1:0]           whole_q, whole_d;
  logic                    irq_en_q, irq_en_d;
  logic [RW-1:0]           irq_base_q, irq_base_d;
  logic                    playing_q, playing_d;
  logic [NUM_CHANNELS-1:0] muted_q, muted_d;
  logic [NUM_CHANNELS-1:0] written_q, written_d;

  // walk and result staging
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [NW-1:0]     nres_q, nres_d;
  tctd_pkg::result_t pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  tctd_pkg::result_t out_q, out_d;
  logic              out_v_q, out_v_d;

  // decode and arithmetic
  logic                        op_whole, op_play, op_pause, op_irq, op_tone;
  logic [CH_W-1:0]             tone_ch;
  logic [tctd_pkg::DIVR_W-1:0] divisor;
  logic [TW-1:0]               whole_calc;
  logic [TW-1:0]               quotient;
  logic                        div_busy;
  logic [TW-1:0]               note_time;
  logic [TW-1:0]               rdata;
  logic [TW-1:0]               rem;
  logic [TW-1:0]               elapsed_ext;
  logic [TW-1:0]               rem_next;
  logic                        emit;

  logic              ram_we;
  logic [CH_W-1:0]   ram_waddr;
  logic [TW-1:0]     ram_wdata;
  tctd_pkg::result_t tone_res, play_res, exp_res;

  // command decode of the latched item
  assign op_whole = !item_q.action && (item_q.reg_a == tctd_pkg::OP_WHOLE_NOTE);
  assign op_play  = !item_q.action && (item_q.reg_a == tctd_pkg::OP_PLAY);
  assign op_pause = !item_q.action && (item_q.reg_a == tctd_pkg::OP_PAUSE);
  assign op_irq   = !item_q.action && (item_q.reg_a == tctd_pkg::OP_IRQ);
  assign op_tone  = !item_q.action && (item_q.reg_a >= tctd_pkg::TONE_BASE)
                 && ({1'b0, item_q.reg_a} <
                     (17'(tctd_pkg::TONE_BASE) + 17'(NUM_CHANNELS)));
  assign tone_ch  = CH_W'(item_q.reg_a - tctd_pkg::TONE_BASE);
  assign divisor  = item_q.reg_c[15:8];

  assign whole_calc = TW'(item_q.reg_b) * TW'(tctd_pkg::US_PER_MS);
  assign note_time  = (divisor == '0) ? tctd_pkg::TIME_MAX : quotient;

  tctd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (whole_q),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // remaining time per channel, unwritten entries read as zero
  tctd_ram #(
    .WIDTH (TW),
    .DEPTH (NUM_CHANNELS)
  ) u_remaining (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_read),
    .raddr_i (ch_q),
    .rdata_o (rdata)
  );

  // channel countdown
  assign rem         = written_q[ch_q] ? rdata : '0;
  assign elapsed_ext = TW'(item_q.elapsed_us);
  assign rem_next    = (rem > elapsed_ext) ? (rem - elapsed_ext) : '0;
  assign emit        = (rem == '0) && !muted_q[ch_q] && (nres_q < NW'(tctd_pkg::MAX_RESULTS));

  assign ram_we    = cmd_i.tone_apply || (cmd_i.chan_apply && (rem != '0));
  assign ram_waddr = cmd_i.tone_apply ? tone_ch : ch_q;
  assign ram_wdata = cmd_i.tone_apply ? note_time : rem_next;

  // result templates
  always_comb begin
    tone_res              = '0;
    tone_res.kind         = tctd_pkg::KIND_TONE;
    tone_res.channel      = tctd_pkg::CHAN_W'(tone_ch);
    tone_res.freq_centihz = item_q.reg_b;
    tone_res.volume       = item_q.reg_c[7:0];
    tone_res.note_time_us = note_time;
    tone_res.playing      = playing_q;

    play_res         = '0;
    play_res.kind    = tctd_pkg::KIND_PLAY;
    play_res.playing = op_play;

    exp_res             = '0;
    exp_res.kind        = tctd_pkg::KIND_EXPIRE;
    exp_res.channel     = tctd_pkg::CHAN_W'(ch_q);
    exp_res.irq_valid   = irq_en_q;
    exp_res.irq_message = irq_en_q ? (irq_base_q + RW'(ch_q)) : '0;
    exp_res.playing     = playing_q;
  end

  // next state of all datapath registers
  always_comb begin
    item_d     = item_q;
    whole_d    = whole_q;
    irq_en_d   = irq_en_q;
    irq_base_d = irq_base_q;
    playing_d  = playing_q;
    muted_d    = muted_q;
    written_d  = written_q;
    ch_d       = ch_q;
    nres_d     = nres_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    out_d      = out_q;
    out_v_d    = out_v_q;

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    if (cmd_i.capture) begin
      item_d = item_i;
    end

    if (cmd_i.exec_cmd) begin
      ch_d   = '0;
      nres_d = '0;
      if (op_whole) begin
        whole_d = whole_calc;
      end
      if (op_play || op_pause) begin
        playing_d = op_play;
        pend_d    = play_res;
        pend_v_d  = 1'b1;
      end
      if (op_irq) begin
        irq_en_d = item_q.reg_b != '0;
        if (item_q.reg_b != '0) begin
          irq_base_d = item_q.reg_b;
        end
      end
    end

    if (cmd_i.tone_apply) begin
      muted_d[tone_ch]   = 1'b0;
      written_d[tone_ch] = 1'b1;
      pend_d             = tone_res;
      pend_v_d           = 1'b1;
    end

    if (cmd_i.chan_apply) begin
      ch_d = ch_q + CH_W'(1);
      if (rem != '0) begin
        written_d[ch_q] = 1'b1;
      end else if (!muted_q[ch_q]) begin
        muted_d[ch_q] = 1'b1;
        if (emit) begin
          if (pend_v_q) begin
            out_d      = pend_q;
            out_d.last = 1'b0;
            out_v_d    = 1'b1;
          end
          pend_d   = exp_res;
          pend_v_d = 1'b1;
          nres_d   = nres_q + NW'(1);
        end
      end
    end

    if (cmd_i.finish_push) begin
      out_d      = pend_q;
      out_d.last = 1'b1;
      out_v_d    = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_q    <= '0;
      irq_en_q   <= 1'b0;
      irq_base_q <= '0;
      playing_q  <= 1'b0;
      muted_q    <= '1;
      written_q  <= '0;
      ch_q       <= '0;
      nres_q     <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      whole_q    <= whole_d;
      irq_en_q   <= irq_en_d;
      irq_base_q <= irq_base_d;
      playing_q  <= playing_d;
      muted_q    <= muted_d;
      written_q  <= written_d;
      ch_q       <= ch_d;
      nres_q     <= nres_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // status back to the controller
  always_comb begin
    status_o            = '0;
    status_o.tick       = item_q.action;
    status_o.tone       = op_tone;
    status_o.div_zero   = divisor == '0;
    status_o.div_busy   = div_busy;
    status_o.out_free   = !out_v_q || out_ready_i;
    status_o.pend_valid = pend_v_q;
    status_o.last_ch    = ch_q == CH_W'(NUM_CHANNELS - 1);
    status_o.emit       = emit;
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

endmodule

>>> rtl/tone_channel_timer_device_top.sv
// commands pass through the decode and finish states, the result coming from the pending slot;
// tone commands also wait on the 26-step bit-serial divider unless the divisor is zero
// ticks visit each channel in a read and an update state, for the registered
// read of the remaining-time memory; one item at a time, a held result stalls
// reset: async active low, all channels muted with zero time, no clearing pass
module tone_channel_timer_device_top #(
  parameter int unsigned NUM_CHANNELS = tctd_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tctd_in_if.sink           in_i,
  tctd_out_if.source        out_o
);

  tctd_pkg::cmd_t    cmd;
  tctd_pkg::status_t status;
  tctd_pkg::item_t   item;
  tctd_pkg::result_t res;
  logic              in_ready;
  logic              out_valid;

  // pack the input payload
  always_comb begin
    item.action     = in_i.action;
    item.reg_a      = in_i.reg_a;
    item.reg_b      = in_i.reg_b;
    item.reg_c      = in_i.reg_c;
    item.elapsed_us = in_i.elapsed_us;
  end

  tctd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tctd_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  // drive the output channel
  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid;
  assign out_o.kind         = res.kind;
  assign out_o.channel      = res.channel;
  assign out_o.freq_centihz = res.freq_centihz;
  assign out_o.volume       = res.volume;
  assign out_o.note_time_us = res.note_time_us;
  assign out_o.irq_valid    = res.irq_valid;
  assign out_o.irq_message  = res.irq_message;
  assign out_o.playing      = res.playing;
  assign out_o.last         = res.last;

`ifndef SYNTHESIS
  // an item is latched only on a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> (in_i.valid && in_i.ready))
    else $error("item latched without a transfer");

  // controller actions that touch the datapath are mutually exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.exec_cmd, cmd.tone_apply, cmd.ram_read, cmd.chan_apply,
              cmd.finish_push}))
    else $error("overlapping datapath commands");

  // the divider never runs while a new item may be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> !in_i.ready)
    else $error("divider busy while idle");

  // the final result of an item leaves only from the pending slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish_push |=> (out_o.valid && out_o.last))
    else $error("final result not presented");
`endif

endmodule
